[design/rxsort_pkg.sv]
// Shared widths, defaults and controller/datapath command and status types
// for the record exchange sorter. No dependencies.
`default_nettype none

package rxsort_pkg;

   localparam int KEY_W           = 32;
   localparam int PAYLOAD_W       = 32;
   localparam int MAX_RECORDS_DEF = 64;

   // read address select for the record store
   localparam logic [1:0] RD_I      = 2'd0;
   localparam logic [1:0] RD_I_NEXT = 2'd1;
   localparam logic [1:0] RD_J      = 2'd2;
   localparam logic [1:0] RD_J_NEXT = 2'd3;

   typedef struct packed {
      logic       load;       // write incoming word at fill count
      logic       rd_en;      // read store into read register
      logic [1:0] rd_sel;
      logic       a_load;     // hold record of outer position
      logic       cmp_step;   // compare held record against read record, swap
      logic       wb_i;       // write held record back to outer position
      logic       i_clr;
      logic       i_inc;
      logic       j_set_next; // inner index to outer index plus one
      logic       j_inc;
      logic       j_clr;
   } rxsort_cmd_type;

   typedef struct packed {
      logic list_end;  // incoming word closes the list
      logic cnt_zero;  // store empty before the incoming word
      logic j_end;     // inner/output index at last record
      logic i_end;     // outer index at second to last record
   } rxsort_status_type;

endpackage

`default_nettype wire

[design/rxsort_channels.sv]
// Valid/ready channel interfaces for record words in and sorted words out.
// Depends on rxsort_pkg.
`default_nettype none

interface rxsort_req_if import rxsort_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_W-1:0]     key;
   logic        [PAYLOAD_W-1:0] payload;
   logic                        last_in;

   modport source (output valid, key, payload, last_in, input ready);
   modport sink   (input valid, key, payload, last_in, output ready);
endinterface

interface rxsort_rsp_if import rxsort_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [KEY_W-1:0]     sorted_key;
   logic        [PAYLOAD_W-1:0] sorted_payload;
   logic                        last_out;

   modport source (output valid, sorted_key, sorted_payload, last_out, input ready);
   modport sink   (input valid, sorted_key, sorted_payload, last_out, output ready);
endinterface

`default_nettype wire

[design/record_exchange_sort_by_key.sv]
// Record exchange sorter: loads one word per cycle until last_in or a full store,
// sorts the records in place (one compare per cycle within each inner pass on the
// single-read, single-write store), then emits each word from a read state and
// an output state while the sink is ready.
// Reset (synchronous) clears the controller and fill count; the store is not cleared.
// Depends on rxsort_pkg, rxsort_channels, rxsort_ctrl and rxsort_datapath.
`default_nettype none

module record_exchange_sort_by_key import rxsort_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rxsort_req_if.sink   req_chan,
   rxsort_rsp_if.source rsp_chan
);

   rxsort_cmd_type    cmd;
   rxsort_status_type status;
   logic              req_ready;
   logic              rsp_valid;

   rxsort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rxsort_datapath #(
      .MAX_RECORDS (MAX_RECORDS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .in_key      (req_chan.key),
      .in_payload  (req_chan.payload),
      .in_last     (req_chan.last_in),
      .out_key     (rsp_chan.sorted_key),
      .out_payload (rsp_chan.sorted_payload),
      .out_last    (rsp_chan.last_out)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

`default_nettype wire

[design/rxsort_datapath.sv]
// Record store, fill count, sort indexes, held record and compare/swap logic.
// Depends on rxsort_pkg; driven by rxsort_ctrl through command/status structs.
`default_nettype none

module rxsort_datapath import rxsort_pkg::*; #(
   parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rxsort_cmd_type              cmd,
   output rxsort_status_type                status,
   input  wire logic signed [KEY_W-1:0]     in_key,
   input  wire logic        [PAYLOAD_W-1:0] in_payload,
   input  wire logic                        in_last,
   output logic signed      [KEY_W-1:0]     out_key,
   output logic             [PAYLOAD_W-1:0] out_payload,
   output logic                             out_last
);

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int RW = KEY_W + PAYLOAD_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_RECORDS - 1);

   logic [RW-1:0] mem [MAX_RECORDS];

   logic [AW-1:0] count_ff, count_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic [AW-1:0] i_ff, i_in;
   logic [AW-1:0] j_ff, j_in;
   logic [RW-1:0] a_ff, a_in;
   logic [RW-1:0] rdata_ff;

   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] waddr;
   logic [RW-1:0] wdata;
   logic          greater;

   assign greater = $signed(a_ff[RW-1 -: KEY_W]) > $signed(rdata_ff[RW-1 -: KEY_W]);

   assign status.list_end = in_last || (count_ff == LAST_SLOT);
   assign status.cnt_zero = (count_ff == '0);
   assign status.j_end    = (j_ff == last_idx_ff);
   assign status.i_end    = ((i_ff + AW'(1)) == last_idx_ff);

   always_comb begin
      case (cmd.rd_sel)
         RD_I:      rd_addr = i_ff;
         RD_I_NEXT: rd_addr = i_ff + AW'(1);
         RD_J:      rd_addr = j_ff;
         RD_J_NEXT: rd_addr = j_ff + AW'(1);
         default:   rd_addr = i_ff;
      endcase
   end

   always_comb begin
      we    = 1'b0;
      waddr = count_ff;
      wdata = {in_key, in_payload};
      if (cmd.load) begin
         we = 1'b1;
      end else if (cmd.cmp_step && greater) begin
         // swap: held record goes to inner slot, read record becomes held
         we    = 1'b1;
         waddr = j_ff;
         wdata = a_ff;
      end else if (cmd.wb_i) begin
         we    = 1'b1;
         waddr = i_ff;
         wdata = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in    = count_ff;
      last_idx_in = last_idx_ff;
      if (cmd.load) begin
         if (status.list_end) begin
            count_in    = '0;
            last_idx_in = count_ff;
         end else begin
            count_in = count_ff + AW'(1);
         end
      end

      i_in = i_ff;
      if (cmd.i_clr) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = i_ff + AW'(1);
      end

      j_in = j_ff;
      if (cmd.j_clr) begin
         j_in = '0;
      end else if (cmd.j_set_next) begin
         j_in = i_ff + AW'(1);
      end else if (cmd.j_inc) begin
         j_in = j_ff + AW'(1);
      end

      a_in = a_ff;
      if (cmd.a_load || (cmd.cmp_step && greater)) begin
         a_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         last_idx_ff <= '0;
         i_ff        <= '0;
         j_ff        <= '0;
      end else begin
         count_ff    <= count_in;
         last_idx_ff <= last_idx_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   assign out_key     = $signed(rdata_ff[RW-1 -: KEY_W]);
   assign out_payload = rdata_ff[PAYLOAD_W-1:0];
   assign out_last    = status.j_end;

endmodule

`default_nettype wire

[design/rxsort_ctrl.sv]
// Sequencer for load, exchange sort and output phases of the record sorter.
// Depends on rxsort_pkg; commands rxsort_datapath.
`default_nettype none

module rxsort_ctrl import rxsort_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rxsort_status_type status,
   output rxsort_cmd_type         cmd
);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_RD_I   = 3'd1;
   localparam logic [2:0] S_GET_I  = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_WB     = 3'd4;
   localparam logic [2:0] S_OUT_RD = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = RD_I;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.list_end) begin
                  if (status.cnt_zero) begin
                     cmd.j_clr = 1'b1;
                     state_in  = S_OUT_RD;
                  end else begin
                     cmd.i_clr = 1'b1;
                     state_in  = S_RD_I;
                  end
               end
            end
         end
         S_RD_I: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_I;
            state_in   = S_GET_I;
         end
         S_GET_I: begin
            cmd.a_load     = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = RD_I_NEXT;
            cmd.j_set_next = 1'b1;
            state_in       = S_CMP;
         end
         S_CMP: begin
            cmd.cmp_step = 1'b1;
            if (status.j_end) begin
               state_in = S_WB;
            end else begin
               // fetch next inner record while this one is compared
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_J_NEXT;
               cmd.j_inc  = 1'b1;
            end
         end
         S_WB: begin
            cmd.wb_i = 1'b1;
            if (status.i_end) begin
               cmd.j_clr = 1'b1;
               state_in  = S_OUT_RD;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_RD_I;
            end
         end
         S_OUT_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_J;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.j_end) begin
                  state_in = S_LOAD;
               end else begin
                  cmd.j_inc = 1'b1;
                  state_in  = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[tb/tb_record_exchange_sort_by_key.sv]
// Self-checking testbench for record_exchange_sort_by_key: drives record words,
// predicts each sorted list and checks every output word. Depends on rxsort_pkg,
// rxsort_channels and the sorter top level.
`timescale 1ns / 100ps

module tb_record_exchange_sort_by_key import rxsort_pkg::*; ();

   localparam int MAX_RECORDS    = MAX_RECORDS_DEF;
   localparam int TARGET_RECORDS = 370;
   localparam int MAX_GAP        = 12;
   localparam int DRAIN_CYCLES   = 64;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DIRECTED_ROWS  = 23;

   localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
   localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

   typedef enum logic {CHECK_PREDICTED, CHECK_TYPED} row_check_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
   } held_record_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
      logic                    last;
   } sorted_word_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0]    payload;
      logic                    last_in;
      row_check_type           check;
      logic signed [KEY_W-1:0] exp_key;
      logic [PAYLOAD_W-1:0]    exp_payload;
      logic                    exp_last;
   } stim_row_type;

   // Single-record lists carry their expected word; the rest go through the predictor.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{KEY_MIN,      32'h0000_0000, 1'b1, CHECK_TYPED, KEY_MIN, 32'h0000_0000, 1'b1},
      '{KEY_MAX,      32'hFFFF_FFFF, 1'b1, CHECK_TYPED, KEY_MAX, 32'hFFFF_FFFF, 1'b1},
      '{32'h0000_0000, 32'h3F80_0000, 1'b1, CHECK_TYPED, 32'h0, 32'h3F80_0000, 1'b1},
      '{KEY_MAX,      32'h0000_0001, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{KEY_MIN,      32'h0000_0002, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0000, 32'h0000_0004, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0001, 32'h0000_0005, 1'b1, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0005, 32'h0000_000A, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0005, 32'h0000_000B, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFD, 32'h0000_000C, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0005, 32'h0000_000D, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFD, 32'h0000_000E, 1'b1, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFE, 32'h1111_1111, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 32'h2222_2222, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0001, 32'h3333_3333, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0002, 32'h4444_4444, 1'b1, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h7FFF_FFFE, 32'h5555_5555, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h0000_0100, 32'hAAAA_AAAA, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'hFFFF_FF9C, 32'hDEAD_BEEF, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{32'h8000_0001, 32'hC0FF_EE00, 1'b1, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{KEY_MIN,      32'h0000_0001, 1'b0, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0},
      '{KEY_MIN,      32'h0000_0002, 1'b1, CHECK_PREDICTED, 32'h0, 32'h0, 1'b0}
   };

   logic clock;
   logic reset;

   rxsort_req_if req_chan ();
   rxsort_rsp_if rsp_chan ();

   record_exchange_sort_by_key #(
      .MAX_RECORDS (MAX_RECORDS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   held_record_type held_records [$];
   sorted_word_type sorted_words_due [$];

   int error_count   = 0;
   int records_sent  = 0;
   int lists_closed  = 0;
   int full_lists    = 0;
   int words_checked = 0;
   int cycle_count   = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("word %0d: %s got %h want %h", words_checked, what, got, want);
      error_count++;
   endtask

   // Hold the record; on a closing word sort the list and queue its sorted words.
   function automatic void take_record(input logic signed [KEY_W-1:0] key,
                                       input logic [PAYLOAD_W-1:0] payload,
                                       input logic last_in);
      held_record_type work [$];
      held_record_type swap;
      int n;
      held_records.push_back('{key, payload});
      if (!last_in && held_records.size() < MAX_RECORDS)
         return;
      work = held_records;
      n = work.size();
      for (int i = 0; i + 1 < n; i++) begin
         for (int j = i + 1; j < n; j++) begin
            if ($signed(work[i].key) > $signed(work[j].key)) begin
               swap    = work[i];
               work[i] = work[j];
               work[j] = swap;
            end
         end
      end
      for (int k = 0; k < n; k++)
         sorted_words_due.push_back('{work[k].key, work[k].payload, k == n - 1});
      if (n == MAX_RECORDS)
         full_lists++;
      lists_closed++;
      held_records.delete();
   endfunction

   function automatic logic [KEY_W-1:0] draw_key(input int mode);
      logic [KEY_W-1:0] k;
      case (mode)
         0: k = $urandom;
         1: k = $urandom_range(0, 8) - 4;       // crowd keys to force ties
         default: begin
            case ($urandom_range(0, 6))
               0: k = KEY_MIN;
               1: k = KEY_MIN + 1;
               2: k = 32'hFFFF_FFFF;
               3: k = 32'h0;
               4: k = 32'h1;
               5: k = KEY_MAX - 1;
               default: k = KEY_MAX;
            endcase
         end
      endcase
      return k;
   endfunction

   // Present one record word and hold it until accepted.
   task automatic drive_record(input logic [KEY_W-1:0] key, input logic [PAYLOAD_W-1:0] payload,
                               input logic last_in, input bit no_gaps);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.key     <= key;
      req_chan.payload <= payload;
      req_chan.last_in <= last_in;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      records_sent++;
   endtask

   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sorted_words_due.size() != 0);
   endtask

   // result side: random stalls, with fast stretches
   initial begin
      int stall;
      bit fast;
      sorted_word_type want;
      fast = 1'b0;
      rsp_chan.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (words_checked % 40 == 0)
            fast = ($urandom_range(0, 2) == 0);
         stall = fast ? 0 : $urandom_range(0, MAX_GAP);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1));
         if (sorted_words_due.size() == 0) begin
            report_mismatch("unexpected word, key", rsp_chan.sorted_key, 32'h0);
         end else begin
            want = sorted_words_due.pop_front();
            if (rsp_chan.sorted_key !== want.key)
               report_mismatch("sorted_key", rsp_chan.sorted_key, want.key);
            if (rsp_chan.sorted_payload !== want.payload)
               report_mismatch("sorted_payload", rsp_chan.sorted_payload, want.payload);
            if (rsp_chan.last_out !== want.last)
               report_mismatch("last_out", 32'(rsp_chan.last_out), 32'(want.last));
         end
         words_checked++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words still due", cycle_count,
               sorted_words_due.size());
      $display("tb_record_exchange_sort_by_key: errors");
      $finish;
   end

   initial begin
      int list_len;
      int key_mode;
      int list_no;
      bit no_gaps;
      bit close_full;
      logic [KEY_W-1:0] key;
      logic [PAYLOAD_W-1:0] payload;
      logic last_in;

      reset = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.key     = '0;
      req_chan.payload = '0;
      req_chan.last_in = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         drive_record(directed_rows[r].key, directed_rows[r].payload,
                      directed_rows[r].last_in, 1'b0);
         if (directed_rows[r].check == CHECK_TYPED)
            sorted_words_due.push_back('{directed_rows[r].exp_key,
                                         directed_rows[r].exp_payload,
                                         directed_rows[r].exp_last});
         else
            take_record(directed_rows[r].key, directed_rows[r].payload,
                        directed_rows[r].last_in);
      end
      wait_for_drain();

      list_no = 0;
      while (records_sent < TARGET_RECORDS) begin
         // two forced full lists: one closed by last_in, one by the store filling
         if (list_no == 2 || list_no == 6 || $urandom_range(0, 24) == 0)
            list_len = MAX_RECORDS;
         else if ($urandom_range(0, 2) == 0)
            list_len = $urandom_range(1, 3);
         else
            list_len = $urandom_range(1, 12);
         close_full = (list_no == 6) ? 1'b0 : (list_no == 2) ? 1'b1 :
                      1'($urandom_range(0, 1));
         key_mode = $urandom_range(0, 3);
         no_gaps  = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < list_len; k++) begin
            key     = draw_key(key_mode > 2 ? 0 : key_mode);
            payload = $urandom;
            if (k + 1 < list_len)
               last_in = 1'b0;
            else if (list_len == MAX_RECORDS)
               last_in = close_full;
            else
               last_in = 1'b1;
            drive_record(key, payload, last_in, no_gaps);
            take_record(key, payload, last_in);
         end
         if ($urandom_range(0, 7) == 0)
            wait_for_drain();
         list_no++;
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d records in %0d lists (%0d filled the store), checked %0d words",
               records_sent, lists_closed, full_lists, words_checked);
      if (error_count == 0)
         $display("tb_record_exchange_sort_by_key: clean");
      else
         $display("tb_record_exchange_sort_by_key: errors");
      $finish;
   end

endmodule

[sim.f]
design/rxsort_pkg.sv
design/rxsort_channels.sv
design/rxsort_datapath.sv
design/rxsort_ctrl.sv
design/record_exchange_sort_by_key.sv
tb/tb_record_exchange_sort_by_key.sv
